// File: design/lti_pkg.sv
// Shared types and constants for the log-table interpolator.
package lti_pkg;

  localparam int unsigned FRAC_BITS   = 24;
  localparam int unsigned GAMMA_W     = 48;
  localparam int unsigned ENTRY_W     = 10;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned DENS_W      = 36;
  localparam int unsigned LOG2_W      = 6 + FRAC_BITS;
  localparam int unsigned NORM_STAGES = 6;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 48;

  localparam int unsigned LOG2_GAMMA_BIAS  = 16 << FRAC_BITS;
  localparam int unsigned LOG2_WEIGHT_BIAS = FRAC_BITS << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAMMA_LOW      = 3'd0,
    CFG_GAMMA_HIGH     = 3'd1,
    CFG_LOG2_GAMMA_LOW = 3'd2,
    CFG_INV_LOG2_STEP  = 3'd3,
    CFG_LAST_ENTRY     = 3'd4,
    CFG_LOG2_SCALE     = 3'd5,
    CFG_SCALE_ENABLED  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_ZERO,
    OP_TOP,
    OP_INTERP
  } op_e;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_DIRECT,
    RES_LIN,
    RES_LOG
  } res_e;

  typedef struct packed {
    logic [GAMMA_W-1:0] gamma_low;
    logic [GAMMA_W-1:0] gamma_high;
    logic [29:0]        log2_gamma_low;
    logic [31:0]        inv_log2_step;
    logic [ENTRY_W-1:0] last_entry;
    logic [DENS_W-1:0]  log2_scale;
    logic               scale_en;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gamma_low:      48'd65536,
    gamma_high:     48'hFFFF_FFFF_FFFF,
    log2_gamma_low: 30'd0,
    inv_log2_step:  32'd65536,
    last_entry:     10'd1020,
    log2_scale:     36'd0,
    scale_en:       1'b0
  };

  typedef struct packed {
    op_e                op;
    logic [ENTRY_W-1:0] addr;
    logic [FRAC_BITS:0] frac;
    logic [VAL_W-1:0]   val;
    logic               zero;
  } item_t;

endpackage

// File: design/log_table_interpolator_core.sv
// Top level of the log-table interpolator: configuration registers and the front/back pipeline.
//
// One command (table write or gamma query) is accepted per clock while busy_o is low, and a
// query's result appears on the result ports, marked by result_valid_o, after the command is
// accepted; table writes give no result. Each query passes through the two pipelined
// log2 units (30 stages each: a 6-step normalizer and one squaring multiplier per fraction bit),
// one in the front end for log2 gamma and one in the back end for the blend weight. The back end
// never stalls, so the two-entry queue between the halves does not fill and busy_o stays low;
// a write is seen by every command accepted after it. The result strobe lasts one cycle and must
// be taken when it appears.
module log_table_interpolator_core import lti_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     action_i,
  input  logic [ENTRY_W-1:0]       entry_index_i,
  input  logic signed [VAL_W-1:0]  entry_log2_value_i,
  input  logic                     entry_is_zero_i,
  input  logic [GAMMA_W-1:0]       gamma_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  output logic                     result_valid_o,
  output logic signed [DENS_W-1:0] log2_density_o,
  output logic                     density_is_zero_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAMMA_LOW:      cfg_q.gamma_low      <= cfg_data_i;
        CFG_GAMMA_HIGH:     cfg_q.gamma_high     <= cfg_data_i;
        CFG_LOG2_GAMMA_LOW: cfg_q.log2_gamma_low <= cfg_data_i[29:0];
        CFG_INV_LOG2_STEP:  cfg_q.inv_log2_step  <= cfg_data_i[31:0];
        CFG_LAST_ENTRY:     cfg_q.last_entry     <= cfg_data_i[ENTRY_W-1:0];
        CFG_LOG2_SCALE:     cfg_q.log2_scale     <= cfg_data_i[DENS_W-1:0];
        CFG_SCALE_ENABLED:  cfg_q.scale_en       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic  item_valid, fifo_full, fifo_valid;
  item_t item, fifo_item;

  lti_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .action_i           (action_i),
    .entry_index_i      (entry_index_i),
    .entry_log2_value_i (entry_log2_value_i),
    .entry_is_zero_i    (entry_is_zero_i),
    .gamma_i            (gamma_i),
    .full_i             (fifo_full),
    .item_valid_o       (item_valid),
    .item_o             (item)
  );

  lti_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (item_valid),
    .data_i  (item),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .data_o  (fifo_item),
    .pop_i   (fifo_valid)
  );

  lti_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .valid_i           (fifo_valid),
    .item_i            (fifo_item),
    .result_valid_o    (result_valid_o),
    .log2_density_o    (log2_density_o),
    .density_is_zero_o (density_is_zero_o)
  );

`ifndef SYNTHESIS
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && density_is_zero_o |-> log2_density_o == '0)
    else $error("zero density with nonzero value");

  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> fifo_full)
    else $error("busy without a full queue");

  a_scale_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !cfg_q.scale_en |-> density_is_zero_o)
    else $error("nonzero result with scaling off");
`endif

endmodule

// File: design/lti_log2.sv
// Pipelined fixed-point log2: leading-zero normalizer then one squaring stage per fraction bit.
module lti_log2 import lti_pkg::*; #(
  parameter int unsigned SideW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [GAMMA_W-1:0]  x_i,
  input  logic [SideW-1:0]    side_i,
  output logic                valid_o,
  output logic [LOG2_W-1:0]   log2_o,
  output logic [SideW-1:0]    side_o
);

  localparam int unsigned NS  = NORM_STAGES;
  localparam int unsigned QS  = FRAC_BITS;
  localparam int unsigned TOT = NS + QS;

  logic               vld_q  [TOT];
  logic [SideW-1:0]   side_q [TOT];
  logic [GAMMA_W-1:0] nx_q   [NS];
  logic [5:0]         nlz_q  [NS];
  logic [31:0]        m_q    [QS];
  logic [FRAC_BITS-1:0] r_q  [QS];
  logic [5:0]         n_q    [QS];

  for (genvar k = 0; k < TOT; k++) begin : g_ctl
    logic             v_in;
    logic [SideW-1:0] s_in;
    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = vld_q[k-1];
      assign s_in = side_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= s_in;
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int unsigned S = 32 >> k;
    logic [GAMMA_W-1:0] x_in;
    logic [5:0]         lz_in;
    logic               hit;
    if (k == 0) begin : g_first
      assign x_in  = (x_i == '0) ? GAMMA_W'(1) : x_i;
      assign lz_in = '0;
    end else begin : g_next
      assign x_in  = nx_q[k-1];
      assign lz_in = nlz_q[k-1];
    end
    assign hit = (x_in[GAMMA_W-1 -: S] == '0);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nx_q[k]  <= hit ? (x_in << S) : x_in;
        nlz_q[k] <= hit ? (lz_in + 6'(S)) : lz_in;
      end
    end
  end

  for (genvar j = 0; j < QS; j++) begin : g_sq
    logic [31:0]          m_in;
    logic [FRAC_BITS-1:0] r_in;
    logic [5:0]           n_in;
    logic [63:0]          p;
    logic [32:0]          q;
    if (j == 0) begin : g_first
      assign m_in = nx_q[NS-1][GAMMA_W-1 -: 32];
      assign r_in = '0;
      assign n_in = 6'(GAMMA_W - 1) - nlz_q[NS-1];
    end else begin : g_next
      assign m_in = m_q[j-1];
      assign r_in = r_q[j-1];
      assign n_in = n_q[j-1];
    end
    assign p = 64'(m_in) * 64'(m_in);
    assign q = p[63:31];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[j] <= q[32] ? q[32:1] : q[31:0];
        r_q[j] <= {r_in[FRAC_BITS-2:0], q[32]};
        n_q[j] <= n_in;
      end
    end
  end

  assign valid_o = vld_q[TOT-1];
  assign side_o  = side_q[TOT-1];
  assign log2_o  = {n_q[QS-1], r_q[QS-1]};

endmodule

// File: design/lti_front.sv
// Front end: takes commands, classifies queries and computes the table position.
module lti_front import lti_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     action_i,
  input  logic [ENTRY_W-1:0]       entry_index_i,
  input  logic signed [VAL_W-1:0]  entry_log2_value_i,
  input  logic                     entry_is_zero_i,
  input  logic [GAMMA_W-1:0]       gamma_i,
  input  logic                     full_i,
  output logic                     item_valid_o,
  output item_t                    item_o
);

  typedef struct packed {
    op_e                op;
    logic [ENTRY_W-1:0] idx;
    logic [VAL_W-1:0]   val;
    logic               zero;
  } fside_t;

  localparam int unsigned SW = $bits(fside_t);

  logic en;
  logic item_valid_q;
  item_t item_q, item_d;

  assign en     = !(item_valid_q && full_i);
  assign busy_o = !en;

  logic               s0_valid_q;
  logic               s0_action_q;
  logic [ENTRY_W-1:0] s0_idx_q;
  logic [VAL_W-1:0]   s0_val_q;
  logic               s0_zero_q;
  logic [GAMMA_W-1:0] s0_gamma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && start_i) begin
      s0_action_q <= action_i;
      s0_idx_q    <= entry_index_i;
      s0_val_q    <= entry_log2_value_i;
      s0_zero_q   <= entry_is_zero_i;
      s0_gamma_q  <= gamma_i;
    end
  end

  fside_t side0;
  always_comb begin
    side0.op   = OP_WRITE;
    side0.idx  = s0_idx_q;
    side0.val  = s0_val_q;
    side0.zero = s0_zero_q;
    if (s0_action_q) begin
      if (!cfg_i.scale_en || s0_gamma_q < cfg_i.gamma_low || s0_gamma_q > cfg_i.gamma_high) begin
        side0.op = OP_ZERO;
      end else if (s0_gamma_q == cfg_i.gamma_high) begin
        side0.op = OP_TOP;
      end else begin
        side0.op = OP_INTERP;
      end
    end
  end

  logic              l_valid;
  logic [LOG2_W-1:0] l_log;
  logic [SW-1:0]     l_side_raw;
  fside_t            l_side;

  lti_log2 #(.SideW(SW)) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_valid_q),
    .x_i     (s0_gamma_q),
    .side_i  (side0),
    .valid_o (l_valid),
    .log2_o  (l_log),
    .side_o  (l_side_raw)
  );
  assign l_side = fside_t'(l_side_raw);

  // offset from the bottom of the grid
  logic signed [31:0] d;
  assign d = $signed(32'(l_log)) - $signed(32'(LOG2_GAMMA_BIAS))
           - $signed(32'(cfg_i.log2_gamma_low));

  logic        p1_valid_q;
  fside_t      p1_side_q;
  logic [29:0] p1_dmag_q;
  logic        p2_valid_q;
  fside_t      p2_side_q;
  logic [61:0] p2_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q   <= 1'b0;
      p2_valid_q   <= 1'b0;
      item_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q   <= l_valid;
      p2_valid_q   <= p1_valid_q;
      item_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_side_q <= l_side;
      p1_dmag_q <= (d > 0) ? d[29:0] : '0;
      p2_side_q <= p1_side_q;
      p2_prod_q <= 62'(p1_dmag_q) * 62'(cfg_i.inv_log2_step);
      item_q    <= item_d;
    end
  end

  logic [45:0]        pos, e_top, posc, fw;
  logic [ENTRY_W-1:0] e, i_raw, i_sel;

  assign pos   = p2_prod_q[61:16];
  assign e     = (cfg_i.last_entry == '0) ? ENTRY_W'(1) : cfg_i.last_entry;
  assign e_top = 46'(e) << FRAC_BITS;
  assign posc  = (pos > e_top) ? e_top : pos;
  assign i_raw = posc[FRAC_BITS +: ENTRY_W];
  assign i_sel = (i_raw > e - ENTRY_W'(1)) ? e - ENTRY_W'(1) : i_raw;
  assign fw    = posc - (46'(i_sel) << FRAC_BITS);

  always_comb begin
    item_d.op   = p2_side_q.op;
    item_d.addr = '0;
    item_d.frac = fw[FRAC_BITS:0];
    item_d.val  = p2_side_q.val;
    item_d.zero = p2_side_q.zero;
    case (p2_side_q.op)
      OP_WRITE:  item_d.addr = p2_side_q.idx;
      OP_TOP:    item_d.addr = e;
      OP_INTERP: item_d.addr = i_sel;
      default:   item_d.addr = '0;
    endcase
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

endmodule

// File: design/lti_fifo.sv
// Two-entry queue between the front end and the back end.
module lti_fifo import lti_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t data_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t data_o,
  input  logic  pop_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign push    = valid_i && !full_o;
  assign pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: design/lti_back.sv
// Back end: shape table, interpolation, weight log2, scaling and saturation.
module lti_back import lti_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     valid_i,
  input  item_t                    item_i,
  output logic                     result_valid_o,
  output logic signed [DENS_W-1:0] log2_density_o,
  output logic                     density_is_zero_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  typedef struct packed {
    logic             zero;
    logic [VAL_W-1:0] val;
  } entry_t;

  typedef struct packed {
    res_e             kind;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] base;
    logic             neg;
    logic [32:0]      t;
  } bside_t;

  localparam int unsigned SW = $bits(bside_t);

  entry_t      mem [TABLE_DEPTH];
  entry_t      rd_lo_q, rd_hi_q;
  logic [31:0] a_lo, a_hi;
  logic        lo_ok, hi_ok;

  assign a_lo  = 32'(item_i.addr);
  assign a_hi  = a_lo + 32'd1;
  assign lo_ok = a_lo < 32'(TABLE_DEPTH);
  assign hi_ok = a_hi < 32'(TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (valid_i && item_i.op == OP_WRITE && lo_ok) begin
      mem[a_lo[AW-1:0]] <= '{zero: item_i.zero, val: item_i.val};
    end
    rd_lo_q <= mem[a_lo[AW-1:0]];
    rd_hi_q <= mem[a_hi[AW-1:0]];
  end

  logic               b1_valid_q;
  op_e                b1_op_q;
  logic [FRAC_BITS:0] b1_frac_q;
  logic               b1_lo_ok_q, b1_hi_ok_q;

  always_ff @(posedge clk_i) begin
    b1_op_q    <= item_i.op;
    b1_frac_q  <= item_i.frac;
    b1_lo_ok_q <= lo_ok;
    b1_hi_ok_q <= hi_ok;
  end

  logic signed [VAL_W-1:0] lo, hi;
  logic                    zlo, zhi;
  logic signed [32:0]      diff, mag;
  logic [FRAC_BITS:0]      w;
  res_e                    kind;

  assign lo   = b1_lo_ok_q ? $signed(rd_lo_q.val) : '0;
  assign hi   = b1_hi_ok_q ? $signed(rd_hi_q.val) : '0;
  assign zlo  = b1_lo_ok_q && rd_lo_q.zero;
  assign zhi  = b1_hi_ok_q && rd_hi_q.zero;
  assign diff = {hi[VAL_W-1], hi} - {lo[VAL_W-1], lo};
  assign mag  = diff[32] ? -diff : diff;
  assign w    = zhi ? ((FRAC_BITS+1)'(1) << FRAC_BITS) - b1_frac_q : b1_frac_q;

  always_comb begin
    kind = RES_ZERO;
    case (b1_op_q)
      OP_TOP: kind = zlo ? RES_ZERO : RES_DIRECT;
      OP_INTERP: begin
        if (!zlo && !zhi) begin
          kind = RES_LIN;
        end else if ((zlo && zhi) || w == '0) begin
          kind = RES_ZERO;
        end else begin
          kind = RES_LOG;
        end
      end
      default: kind = RES_ZERO;
    endcase
  end

  logic               b2_valid_q;
  res_e               b2_kind_q;
  logic [VAL_W-1:0]   b2_lo_q, b2_base_q, b2_mag_q;
  logic               b2_neg_q;
  logic [FRAC_BITS:0] b2_frac_q, b2_w_q;

  always_ff @(posedge clk_i) begin
    b2_kind_q <= kind;
    b2_lo_q   <= lo;
    b2_base_q <= zhi ? lo : hi;
    b2_mag_q  <= mag[VAL_W-1:0];
    b2_neg_q  <= diff[32];
    b2_frac_q <= b1_frac_q;
    b2_w_q    <= w;
  end

  logic [56:0] prod;
  bside_t      side2;

  assign prod       = 57'(b2_mag_q) * 57'(b2_frac_q);
  assign side2.kind = b2_kind_q;
  assign side2.lo   = b2_lo_q;
  assign side2.base = b2_base_q;
  assign side2.neg  = b2_neg_q;
  assign side2.t    = prod[56:FRAC_BITS];

  logic              l_valid;
  logic [LOG2_W-1:0] l_log;
  logic [SW-1:0]     l_side_raw;
  bside_t            l_side;

  lti_log2 #(.SideW(SW)) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (1'b1),
    .valid_i (b2_valid_q),
    .x_i     (GAMMA_W'(b2_w_q)),
    .side_i  (side2),
    .valid_o (l_valid),
    .log2_o  (l_log),
    .side_o  (l_side_raw)
  );
  assign l_side = bside_t'(l_side_raw);

  logic signed [33:0] lo34, base34, t34, v;
  assign lo34   = 34'($signed(l_side.lo));
  assign base34 = 34'($signed(l_side.base));
  assign t34    = $signed(34'(l_side.t));

  always_comb begin
    case (l_side.kind)
      RES_LIN:    v = l_side.neg ? lo34 - t34 : lo34 + t34;
      RES_LOG:    v = base34 + $signed(34'(l_log)) - $signed(34'(LOG2_WEIGHT_BIAS));
      RES_DIRECT: v = lo34;
      default:    v = '0;
    endcase
  end

  logic               b3_valid_q, b3_zero_q;
  logic signed [33:0] b3_v_q;

  always_ff @(posedge clk_i) begin
    b3_v_q    <= v;
    b3_zero_q <= (l_side.kind == RES_ZERO);
  end

  logic signed [36:0]       sum;
  logic signed [DENS_W-1:0] sat;
  assign sum = 37'(b3_v_q) + 37'($signed(cfg_i.log2_scale));

  always_comb begin
    if (sum[36] != sum[35]) begin
      sat = sum[36] ? {1'b1, {(DENS_W-1){1'b0}}} : {1'b0, {(DENS_W-1){1'b1}}};
    end else begin
      sat = sum[DENS_W-1:0];
    end
  end

  logic                     res_valid_q, res_zero_q;
  logic signed [DENS_W-1:0] res_dens_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      b1_valid_q  <= valid_i && item_i.op != OP_WRITE;
      b2_valid_q  <= b1_valid_q;
      b3_valid_q  <= l_valid;
      res_valid_q <= b3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_zero_q <= b3_zero_q;
    res_dens_q <= b3_zero_q ? '0 : sat;
  end

  assign result_valid_o    = res_valid_q;
  assign log2_density_o    = res_dens_q;
  assign density_is_zero_o = res_zero_q;

endmodule

// File: tb/sv/tb_log_table_interpolator_core.sv
// Self-checking testbench for log_table_interpolator_core: table writes, register writes and gamma queries.
`timescale 1ns / 1ps

module tb_log_table_interpolator_core;
  import lti_pkg::*;

  localparam int DEPTH = 1024;
  localparam int LATENCY = 69;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic action_i = 1'b0;
  logic [ENTRY_W-1:0] entry_index_i = '0;
  logic signed [VAL_W-1:0] entry_log2_value_i = '0;
  logic entry_is_zero_i = 1'b0;
  logic [GAMMA_W-1:0] gamma_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic result_valid_o;
  logic signed [DENS_W-1:0] log2_density_o;
  logic density_is_zero_o;

  int errors = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  log_table_interpolator_core DUT (.*);

  typedef struct {
    logic signed [DENS_W-1:0] dens;
    logic                     zero;
  } density_t;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  class density_scoreboard;
    logic signed [31:0] tval [DEPTH];
    bit                 tzero [DEPTH];
    logic [47:0] g_low = 48'd65536, g_high = 48'hFFFF_FFFF_FFFF;
    logic [29:0] lg_low = '0;
    logic [31:0] inv_step = 32'd65536;
    logic [9:0]  last = 10'd1020;
    logic signed [35:0] lscale = '0;
    bit scale_on = 1'b0;
    density_t pending [$];

    function void set_reg(cfg_idx_e idx, logic [47:0] d);
      case (idx)
        CFG_GAMMA_LOW:      g_low = d;
        CFG_GAMMA_HIGH:     g_high = d;
        CFG_LOG2_GAMMA_LOW: lg_low = d[29:0];
        CFG_INV_LOG2_STEP:  inv_step = d[31:0];
        CFG_LAST_ENTRY:     last = d[9:0];
        CFG_LOG2_SCALE:     lscale = d[35:0];
        CFG_SCALE_ENABLED:  scale_on = d[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] log2_q(logic [63:0] x);
      int n;
      logic [63:0] m, r;
      if (x == 0) x = 1;
      n = 0;
      r = 0;
      while (n < 63 && (x >> (n + 1)) != 0) n++;
      m = (n >= 31) ? (x >> (n - 31)) : (x << (31 - n));
      for (int k = 0; k < FRAC_BITS; k++) begin
        m = (m * m) >> 31;
        r = r << 1;
        if (m >> 32) begin
          m = m >> 1;
          r[0] = 1'b1;
        end
      end
      return (64'(n) << FRAC_BITS) | r;
    endfunction

    function logic [35:0] sat(longint v);
      if (v > 64'sd34359738367) v = 64'sd34359738367;
      if (v < -64'sd34359738368) v = -64'sd34359738368;
      return v[35:0];
    endfunction

    function void note_item(bit act, logic [9:0] idx, logic signed [31:0] val, bit z,
                            logic [47:0] g);
      density_t r;
      longint e, d, lo, hi, v, diff;
      logic [127:0] p;
      logic [63:0] pos, i, f, w, mag, t;
      if (!act) begin
        tval[idx] = val;
        tzero[idx] = z;
        return;
      end
      r.dens = '0;
      r.zero = 1'b1;
      if (scale_on && g >= g_low && g <= g_high) begin
        e = (last == 0) ? 1 : last;
        if (g == g_high) begin
          if (!tzero[e]) begin
            r.dens = sat(longint'(tval[e]) + lscale);
            r.zero = 1'b0;
          end
        end else begin
          d = longint'(log2_q(64'(g))) - (longint'(16) << FRAC_BITS) - longint'(lg_low);
          p = 128'(d) * 128'(inv_step);
          pos = (d <= 0) ? 0 : 64'(p >> 16);
          if (pos > (64'(e) << FRAC_BITS)) pos = 64'(e) << FRAC_BITS;
          i = pos >> FRAC_BITS;
          if (i > e - 1) i = e - 1;
          f = pos - (i << FRAC_BITS);
          lo = tval[i];
          hi = tval[i + 1];
          if (!tzero[i] && !tzero[i + 1]) begin
            diff = hi - lo;
            mag = (diff < 0) ? -diff : diff;
            t = (mag * f) >> FRAC_BITS;
            v = (diff < 0) ? lo - longint'(t) : lo + longint'(t);
            r.dens = sat(v + lscale);
            r.zero = 1'b0;
          end else if (!(tzero[i] && tzero[i + 1])) begin
            if (tzero[i + 1]) begin
              w = (64'd1 << FRAC_BITS) - f;
              v = lo;
            end else begin
              w = f;
              v = hi;
            end
            if (w != 0) begin
              v += longint'(log2_q(w)) - (longint'(FRAC_BITS) << FRAC_BITS);
              r.dens = sat(v + lscale);
              r.zero = 1'b0;
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    task check_result(logic signed [35:0] dens, logic zero);
      density_t x;
      if (pending.size() == 0) begin
        report("unexpected result", dens, 0);
        return;
      end
      x = pending.pop_front();
      if (zero !== x.zero) report("density_is_zero", zero, x.zero);
      if (dens !== x.dens) report("log2_density", dens, x.dens);
    endtask
  endclass

  density_scoreboard sb = new();

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
    if (rst_ni && start_i && !busy_o)
      sb.note_item(action_i, entry_index_i, entry_log2_value_i, entry_is_zero_i, gamma_i);
    if (rst_ni && result_valid_o) sb.check_result(log2_density_o, density_is_zero_o);
  end

  task automatic send_item(bit act, logic [9:0] idx, logic [31:0] val, bit z, logic [47:0] g);
    while (!no_idle && $urandom_range(99) < 21) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= act;
    entry_index_i <= idx;
    entry_log2_value_i <= val;
    entry_is_zero_i <= z;
    gamma_i <= g;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [47:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, d);
    @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_entry(int idx, logic [31:0] val, bit z);
    send_item(1'b0, idx[9:0], val, z, 48'($urandom));
  endtask

  task automatic fill_table(int zero_pct);
    for (int k = 0; k <= 1020; k++)
      write_entry(k, $urandom, $urandom_range(99) < zero_pct);
  endtask

  function automatic logic [47:0] rand_gamma();
    logic [47:0] g;
    g = {$urandom, $urandom};
    case ($urandom_range(7))
      0: g = sb.g_low;
      1: g = sb.g_high;
      2: g = sb.g_low + $urandom_range(3) - 1;
      3: g = sb.g_high + $urandom_range(2) - 1;
      4: g = g >> $urandom_range(47);
      default: g = sb.g_low + ((sb.g_high - sb.g_low) >> $urandom_range(40)) * 48'($urandom_range(255)) / 48'd256;
    endcase
    return g;
  endfunction

  task automatic random_phase(int n, bit wide);
    int idx;
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        idx = wide ? $urandom_range(1023) : $urandom_range(1020);
        write_entry(idx, $urandom, $urandom_range(3) == 0);
      end else begin
        send_item(1'b1, 10'($urandom), $urandom, 1'($urandom_range(1)), rand_gamma());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of entry values, zero patterns, reset config (scale off), then boundary gammas with scale on
    write_entry(0, 32'h8000_0000, 1'b0);
    write_entry(1, 32'h7FFF_FFFF, 1'b0);
    write_entry(2, 32'h0, 1'b1);
    write_entry(3, 32'h0100_0000, 1'b0);
    write_entry(4, 32'h0, 1'b1);
    write_entry(1023, 32'h1234_5678, 1'b0);
    send_item(1'b1, '0, '0, 1'b0, 48'd65536 * 2);
    drain();
    fill_table(25);
    drain();
    write_reg(CFG_SCALE_ENABLED, 48'd1);
    write_reg(CFG_LOG2_SCALE, 48'h0_0000_0000);
    drain();
    send_item(1'b1, '0, '0, 1'b0, 48'd0);
    send_item(1'b1, '0, '0, 1'b0, 48'd65535);
    send_item(1'b1, '0, '0, 1'b0, 48'd65536);
    send_item(1'b1, '0, '0, 1'b0, 48'd98304);
    send_item(1'b1, '0, '0, 1'b0, 48'hFFFF_FFFF_FFFE);
    send_item(1'b1, '0, '0, 1'b0, 48'hFFFF_FFFF_FFFF);
    send_item(1'b1, 10'h3FF, 32'hFFFF_FFFF, 1'b1, 48'h0001_0000_0000);
    drain();

    // setting sweep: extremes in phases 1 to 6, scaling off in phase 7
    for (int ph = 0; ph < 8; ph++) begin
      logic [47:0] lo, hi;
      lo = (ph == 1) ? 48'd65536 : 48'd65536 << $urandom_range(20);
      hi = (ph == 2) ? 48'hFFFF_FFFF_FFFF : lo + ({$urandom, $urandom} >> $urandom_range(47));
      if (hi < lo) hi = 48'hFFFF_FFFF_FFFF;
      write_reg(CFG_GAMMA_LOW, lo);
      write_reg(CFG_GAMMA_HIGH, hi);
      write_reg(CFG_LOG2_GAMMA_LOW, (ph == 3) ? 48'd536870912 :
                (ph == 4) ? 48'd0 : 48'(sb.log2_q(64'(lo)) - (64'd16 << FRAC_BITS)));
      write_reg(CFG_INV_LOG2_STEP, (ph == 3) ? 48'hFFFF_FFFF : (ph == 4) ? 48'd0 :
                48'($urandom_range(32'h0100_0000)));
      write_reg(CFG_LAST_ENTRY, (ph == 5) ? 48'd6 : (ph == 6) ? 48'd1020 :
                48'(6 * $urandom_range(1, 170)));
      write_reg(CFG_LOG2_SCALE, (ph == 5) ? 48'h7_FFFF_FFFF : (ph == 6) ? 48'h8_0000_0000 :
                48'({$urandom_range(15), $urandom}));
      write_reg(CFG_SCALE_ENABLED, (ph == 7) ? 48'd0 : 48'd1);
      no_idle = (ph == 4);
      random_phase(115, ph > 4);
      drain();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: sim.f
design/lti_pkg.sv
design/lti_log2.sv
design/lti_front.sv
design/lti_fifo.sv
design/lti_back.sv
design/log_table_interpolator_core.sv
tb/sv/tb_log_table_interpolator_core.sv
